// ===== rtl/tdpt_pkg.sv =====
package tdpt_pkg;

  // Candidate width and derived widths.
  localparam int unsigned WIDTH = 32;
  // Odd divisor reaches at most 2^ceil(WIDTH/2) + 1.
  localparam int unsigned DW    = (WIDTH + 1) / 2 + 1;
  localparam int unsigned SQW   = 2 * DW;
  localparam int unsigned CNTW  = $clog2(WIDTH + 1);

  // Microprogram addresses.
  localparam int unsigned UPCW       = 4;
  localparam logic [UPCW-1:0] STEP_IDLE  = 4'd0;
  localparam logic [UPCW-1:0] STEP_TWO   = 4'd1;
  localparam logic [UPCW-1:0] STEP_EVEN  = 4'd2;
  localparam logic [UPCW-1:0] STEP_SQ    = 4'd3;
  localparam logic [UPCW-1:0] STEP_BOUND = 4'd4;
  localparam logic [UPCW-1:0] STEP_GO    = 4'd5;
  localparam logic [UPCW-1:0] STEP_WAIT  = 4'd6;
  localparam logic [UPCW-1:0] STEP_TEST  = 4'd7;
  localparam logic [UPCW-1:0] STEP_INC   = 4'd8;
  localparam logic [UPCW-1:0] STEP_PRIME = 4'd9;
  localparam logic [UPCW-1:0] STEP_COMP  = 4'd10;

  // Jump conditions; the jump is taken when the condition is true.
  typedef enum logic [2:0] {
    COND_NEVER     = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_NO_START  = 3'd2,
    COND_IS_TWO    = 3'd3,
    COND_LOW_EVEN  = 3'd4,
    COND_SQ_GT     = 3'd5,
    COND_REM_BUSY  = 3'd6,
    COND_REM_ZERO  = 3'd7
  } cond_e;

  typedef struct packed {
    cond_e           cond;
    logic [UPCW-1:0] tgt;
    logic            ld;    // load candidate, divisor := 3
    logic            sq;    // register divisor squared
    logic            go;    // launch remainder unit
    logic            inc;   // divisor += 2
    logic            emit;  // send result
    logic            res;   // result value
  } ctl_t;

  // Remainder unit status.
  typedef struct packed {
    logic busy;
    logic zero;
  } rem_stat_t;

  function automatic ctl_t ucode(logic [UPCW-1:0] a);
    ctl_t c;
    c = '{cond: COND_NEVER, tgt: STEP_IDLE, default: 1'b0};
    case (a)
      STEP_IDLE: begin
        c.cond = COND_NO_START; c.tgt = STEP_IDLE; c.ld = 1'b1;
      end
      STEP_TWO: begin
        c.cond = COND_IS_TWO; c.tgt = STEP_PRIME;
      end
      STEP_EVEN: begin
        c.cond = COND_LOW_EVEN; c.tgt = STEP_COMP;
      end
      STEP_SQ: begin
        c.sq = 1'b1;
      end
      STEP_BOUND: begin
        c.cond = COND_SQ_GT; c.tgt = STEP_PRIME;
      end
      STEP_GO: begin
        c.go = 1'b1;
      end
      STEP_WAIT: begin
        c.cond = COND_REM_BUSY; c.tgt = STEP_WAIT;
      end
      STEP_TEST: begin
        c.cond = COND_REM_ZERO; c.tgt = STEP_COMP;
      end
      STEP_INC: begin
        c.cond = COND_ALWAYS; c.tgt = STEP_SQ; c.inc = 1'b1;
      end
      STEP_PRIME: begin
        c.cond = COND_ALWAYS; c.tgt = STEP_IDLE; c.emit = 1'b1; c.res = 1'b1;
      end
      STEP_COMP: begin
        c.cond = COND_ALWAYS; c.tgt = STEP_IDLE; c.emit = 1'b1;
      end
      default: begin
        c.cond = COND_ALWAYS; c.tgt = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/tdpt_rem.sv =====
// Restoring remainder, one dividend bit per cycle.
module tdpt_rem (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         go_i,
  input  logic [tdpt_pkg::WIDTH-1:0]   dividend_i,
  input  logic [tdpt_pkg::DW-1:0]      divisor_i,
  output tdpt_pkg::rem_stat_t          stat_o
);

  logic [tdpt_pkg::CNTW-1:0]  cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic [tdpt_pkg::WIDTH-1:0] dv_q, dv_d;
  logic [tdpt_pkg::DW-1:0]    r_q, r_d;
  logic [tdpt_pkg::DW:0]      r_sh, r_sub;

  always_comb begin
    r_sh  = {r_q, dv_q[tdpt_pkg::WIDTH-1]};
    r_sub = r_sh - {1'b0, divisor_i};
    cnt_d  = cnt_q;
    busy_d = busy_q;
    dv_d   = dv_q;
    r_d    = r_q;
    if (go_i) begin
      cnt_d  = tdpt_pkg::CNTW'(tdpt_pkg::WIDTH);
      busy_d = 1'b1;
      dv_d   = dividend_i;
      r_d    = '0;
    end else if (busy_q) begin
      dv_d  = {dv_q[tdpt_pkg::WIDTH-2:0], 1'b0};
      r_d   = (r_sh >= {1'b0, divisor_i}) ? r_sub[tdpt_pkg::DW-1:0]
                                          : r_sh[tdpt_pkg::DW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == tdpt_pkg::CNTW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q <= dv_d;
    r_q  <= r_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.zero = (r_q == '0);

  a_cnt_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("remainder unit busy with zero count");

  a_go_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i |=> busy_q && cnt_q == tdpt_pkg::CNTW'(tdpt_pkg::WIDTH))
    else $error("remainder unit did not start");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == tdpt_pkg::CNTW'(1) && !go_i) |=> !busy_q)
    else $error("remainder unit overran");

endmodule

// ===== rtl/trial_division_prime_test.sv =====
// Trial-division primality test.
// A transaction enters when start is high and busy is low at a rising
// clock edge; candidate_i is sampled at that edge. Exactly one result
// transaction follows: valid_o is high for one cycle with is_prime_o.
// The receiver cannot stall, so the result must be taken in that cycle.
// busy stays high from the accepting edge until the result cycle;
// start is ignored while busy is high. A new start may be given in the
// cycle that carries the result.
// Two, even numbers and numbers below 2 are settled without any division.
// Odd candidates try each odd divisor 3, 5, ... up to sqrt(candidate):
// the remainder unit retires one dividend bit per cycle and sets the
// step time. Worst case for WIDTH=32 is about 32768 divisors. One item at a time.
// Control is a microprogram in a constant table: one control word per
// step, a step counter, and conditional jumps on datapath flags.
// Reset (rst_ni low, asynchronous) returns the step counter to idle and
// drops valid_o; no transaction in flight survives it.
module trial_division_prime_test (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [tdpt_pkg::WIDTH-1:0] candidate_i,
  output logic                       valid_o,
  output logic                       is_prime_o
);

  // Sequencer
  logic [tdpt_pkg::UPCW-1:0] upc_q, upc_d;
  tdpt_pkg::ctl_t            ctl;
  logic                      jump;

  // Datapath
  logic [tdpt_pkg::WIDTH-1:0] n_q, n_d;
  logic [tdpt_pkg::DW-1:0]    d_q, d_d;
  logic [tdpt_pkg::SQW-1:0]   sq_q, sq_d;
  logic                       valid_q, prime_q;
  tdpt_pkg::rem_stat_t        rem_stat;
  logic                       sq_gt;
  logic                       rem_go;

  assign ctl   = tdpt_pkg::ucode(upc_q);
  // Bound check: stop once divisor squared exceeds the candidate.
  assign sq_gt = sq_q > {{(tdpt_pkg::SQW - tdpt_pkg::WIDTH){1'b0}}, n_q};
  assign rem_go = ctl.go;

  always_comb begin
    case (ctl.cond)
      tdpt_pkg::COND_NEVER:    jump = 1'b0;
      tdpt_pkg::COND_ALWAYS:   jump = 1'b1;
      tdpt_pkg::COND_NO_START: jump = !start;
      tdpt_pkg::COND_IS_TWO:   jump = (n_q == tdpt_pkg::WIDTH'(2));
      // below two, or even (two was handled one step earlier)
      tdpt_pkg::COND_LOW_EVEN: jump = (n_q < tdpt_pkg::WIDTH'(2)) || !n_q[0];
      tdpt_pkg::COND_SQ_GT:    jump = sq_gt;
      tdpt_pkg::COND_REM_BUSY: jump = rem_stat.busy;
      tdpt_pkg::COND_REM_ZERO: jump = rem_stat.zero;
      default:                 jump = 1'b0;
    endcase
    upc_d = jump ? ctl.tgt : upc_q + 1'b1;
  end

  always_comb begin
    n_d  = n_q;
    d_d  = d_q;
    sq_d = sq_q;
    if (ctl.ld && start) begin
      n_d = candidate_i;
      d_d = tdpt_pkg::DW'(3);
    end
    if (ctl.sq) begin
      sq_d = tdpt_pkg::SQW'(d_q) * tdpt_pkg::SQW'(d_q);
    end
    if (ctl.inc) begin
      d_d = d_q + tdpt_pkg::DW'(2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q   <= tdpt_pkg::STEP_IDLE;
      valid_q <= 1'b0;
    end else begin
      upc_q   <= upc_d;
      valid_q <= ctl.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    d_q     <= d_d;
    sq_q    <= sq_d;
    prime_q <= ctl.res;
  end

  tdpt_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (rem_go),
    .dividend_i (n_q),
    .divisor_i  (d_q),
    .stat_o     (rem_stat)
  );

  assign busy       = (upc_q != tdpt_pkg::STEP_IDLE);
  assign valid_o    = valid_q;
  assign is_prime_o = prime_q;

  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result while still busy");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start");

  a_prime_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && is_prime_o) |-> (n_q == tdpt_pkg::WIDTH'(2) || n_q[0]))
    else $error("even number reported prime");

  a_go_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_go |-> !rem_stat.busy)
    else $error("remainder unit launched while busy");

endmodule
